// ===== design/hierarchical_binomial_bcast_schedule_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binomial broadcast schedule unit
// Shared wrappers for concurrent checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef HIERARCHICAL_BINOMIAL_BCAST_SCHEDULE_UNIT_MACROS_SVH
`define HIERARCHICAL_BINOMIAL_BCAST_SCHEDULE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HBBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HBBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hbbs_pkg.sv =====
// ---------------------------------------------------------------------------
// hbbs_pkg
// Types and constants of the binomial broadcast schedule unit.
// ---------------------------------------------------------------------------
package hbbs_pkg;

  localparam int MAX_RANKS  = 1024;
  localparam int RANK_W     = 10;
  localparam int REG_W      = 11;
  localparam int PROD_W     = 21;

  // configuration register indexes
  localparam logic REG_COMM_SIZE  = 1'b0;
  localparam logic REG_GROUP_SIZE = 1'b1;

  // action codes
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // phase codes
  localparam logic [1:0] PH_ROOT  = 2'd0;
  localparam logic [1:0] PH_INTER = 2'd1;
  localparam logic [1:0] PH_INTRA = 2'd2;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] root;
  } item_t;

  typedef struct packed {
    logic              op;
    logic [RANK_W-1:0] peer;
    logic [1:0]        phase;
    logic              is_last;
  } result_t;

  // zero reads as one, oversize saturates at MAX_RANKS
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > REG_W'(MAX_RANKS)) begin
      r = REG_W'(MAX_RANKS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/hierarchical_binomial_bcast_schedule_unit.sv =====
// ---------------------------------------------------------------------------
// hierarchical_binomial_bcast_schedule_unit
// Emits one rank's receive/send schedule for a two-level binomial broadcast.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  item      in   item_valid / item_ready      item_t   {rank, root}
//  result    out  result_valid / result_ready  result_t {op, peer, phase, is_last}
//  cfg       in   cfg_we (no wait)             cfg_index, cfg_data
//
//  A transaction passes through accept, division, setup, binomial mask
//  stepping over the tree levels and flush. The pace is set by the shared
//  1-bit-per-cycle divider (two 11-step passes) and the single shift/add
//  unit stepping the binomial masks.
//  item_ready is high only in idle. A stalled result stalls the sequencer
//  when a new action must be staged. Reset is synchronous and clears control.
// ---------------------------------------------------------------------------
`include "hierarchical_binomial_bcast_schedule_unit_macros.svh"

module hierarchical_binomial_bcast_schedule_unit
  import hbbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RANK,
    ST_DIV_SIZE,
    ST_ROOT,
    ST_TREE_UP,
    ST_TREE_DOWN,
    ST_FLUSH
  } state_t;

  state_t            state;

  // configuration, stored already clamped
  logic [REG_W-1:0]  size_c;
  logic [REG_W-1:0]  g;

  // transaction operands and derived values
  logic [RANK_W-1:0] rank_q;
  logic [RANK_W-1:0] root_q;
  logic [RANK_W-1:0] grp_idx;
  logic [RANK_W-1:0] local_idx;
  logic [REG_W-1:0]  size_quo;
  logic [RANK_W-1:0] size_rem;
  logic [RANK_W-1:0] base;
  logic [REG_W-1:0]  n_groups;
  logic [REG_W-1:0]  grp_len;

  // divider
  logic [REG_W-1:0]  dq;
  logic [REG_W-1:0]  rem;
  logic [3:0]        div_cnt;
  logic [REG_W-1:0]  trial;
  logic              trial_ge;
  logic [REG_W-1:0]  rem_next;
  logic [REG_W-1:0]  dq_next;

  // tree sequencer
  logic [1:0]        cur_phase;
  logic [3:0]        k;
  logic              is_inter;
  logic [REG_W-1:0]  idx;
  logic [REG_W-1:0]  lsize;
  logic [RANK_W-1:0] center;
  logic [3:0]        sh;
  logic [REG_W-1:0]  mask;
  logic [PROD_W-1:0] step;
  logic [PROD_W-1:0] sum_up;
  logic [RANK_W-1:0] diff_dn;
  logic              send_ok;

  // staging of one action so that is_last is known before release
  result_t           hold;
  logic              hold_valid;
  logic              out_free;
  logic              can_push;
  logic              stage_req;
  logic              out_load;
  logic              last_done;

  assign item_ready = (state == ST_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign can_push   = !hold_valid || out_free;
  assign last_done  = result_valid && result_ready && result.is_last;

  // divider step: one quotient bit per cycle
  always_comb begin
    trial    = {rem[REG_W-2:0], dq[REG_W-1]};
    trial_ge = (trial >= g);
    rem_next = trial_ge ? (trial - g) : trial;
    dq_next  = {dq[REG_W-2:0], trial_ge};
  end

  // shared shift/add unit for peer computation
  always_comb begin
    is_inter = (cur_phase == PH_INTER);
    idx      = is_inter ? {1'b0, grp_idx} : {1'b0, local_idx};
    lsize    = is_inter ? n_groups : grp_len;
    center   = is_inter ? base : rank_q;
    sh       = (state == ST_TREE_UP) ? k : (k - 4'd1);
    mask     = REG_W'(1) << sh;
    step     = {{(PROD_W-REG_W){1'b0}}, (is_inter ? g : REG_W'(1))} << sh;
    sum_up   = {{(PROD_W-RANK_W){1'b0}}, center} + step;
    diff_dn  = center - step[RANK_W-1:0];
    send_ok  = (idx < lsize) && (sum_up < {{(PROD_W-REG_W){1'b0}}, size_c});
  end

  // a new action wants the staging slot; the staged one moves out
  always_comb begin
    case (state)
      ST_ROOT:      stage_req = (root_q != '0) && ((rank_q == root_q) || (rank_q == '0));
      ST_TREE_UP:   stage_req = (mask < lsize) && idx[k];
      ST_TREE_DOWN: stage_req = (k != '0) && send_ok;
      default:      stage_req = 1'b0;
    endcase
    out_load = hold_valid && out_free && (stage_req || (state == ST_FLUSH));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_c <= REG_W'(1);
      g      <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMM_SIZE:  size_c <= clamp_reg(cfg_data);
        REG_GROUP_SIZE: g      <= clamp_reg(cfg_data);
        default:        ;
      endcase
    end
  end

  // sequencer, staging and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      div_cnt      <= '0;
      k            <= '0;
      cur_phase    <= PH_INTER;
    end else begin
      // output register: the staged action leaves, marked final on flush
      if (out_load) begin
        result       <= '{op: hold.op, peer: hold.peer, phase: hold.phase,
                          is_last: (state == ST_FLUSH)};
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            rank_q  <= item.rank;
            root_q  <= item.root;
            dq      <= {1'b0, item.rank};
            rem     <= '0;
            div_cnt <= '0;
            state   <= ST_DIV_RANK;
          end
        end
        ST_DIV_RANK: begin
          if (div_cnt == 4'(REG_W-1)) begin
            grp_idx   <= dq_next[RANK_W-1:0];
            local_idx <= rem_next[RANK_W-1:0];
            dq        <= size_c;
            rem       <= '0;
            div_cnt   <= '0;
            state     <= ST_DIV_SIZE;
          end else begin
            dq      <= dq_next;
            rem     <= rem_next;
            div_cnt <= div_cnt + 4'd1;
          end
        end
        ST_DIV_SIZE: begin
          dq      <= dq_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(REG_W-1)) begin
            size_quo <= dq_next;
            size_rem <= rem_next[RANK_W-1:0];
            state    <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          // derived group geometry; rewritten harmlessly while stalled
          base     <= rank_q - local_idx;
          n_groups <= size_quo + {{(REG_W-1){1'b0}}, (size_rem != '0)};
          if ({1'b0, grp_idx} == size_quo) begin
            grp_len <= size_c - {1'b0, rank_q - local_idx};
          end else begin
            grp_len <= g;
          end
          if ((root_q != '0) && ((rank_q == root_q) || (rank_q == '0))) begin
            if (can_push) begin
              hold.op      <= (rank_q == root_q) ? OP_SEND : OP_RECV;
              hold.peer    <= (rank_q == root_q) ? '0 : root_q;
              hold.phase   <= PH_ROOT;
              hold.is_last <= 1'b0;
              hold_valid   <= 1'b1;
              k            <= '0;
              cur_phase    <= (local_idx == '0) ? PH_INTER : PH_INTRA;
              state        <= ST_TREE_UP;
            end
          end else begin
            k         <= '0;
            cur_phase <= (local_idx == '0) ? PH_INTER : PH_INTRA;
            state     <= ST_TREE_UP;
          end
        end
        ST_TREE_UP: begin
          // search for the parent bit, lowest first
          if (!(mask < lsize)) begin
            state <= ST_TREE_DOWN;
          end else if (idx[k]) begin
            if (can_push) begin
              hold.op      <= OP_RECV;
              hold.peer    <= diff_dn;
              hold.phase   <= cur_phase;
              hold.is_last <= 1'b0;
              hold_valid   <= 1'b1;
              state        <= ST_TREE_DOWN;
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        ST_TREE_DOWN: begin
          // children, highest mask first; k counts remaining masks
          if (k == '0) begin
            if (cur_phase == PH_INTER) begin
              cur_phase <= PH_INTRA;
              state     <= ST_TREE_UP;
            end else begin
              state <= ST_FLUSH;
            end
          end else if (send_ok) begin
            if (can_push) begin
              hold.op      <= OP_SEND;
              hold.peer    <= sum_up[RANK_W-1:0];
              hold.phase   <= cur_phase;
              hold.is_last <= 1'b0;
              hold_valid   <= 1'b1;
              k            <= k - 4'd1;
            end
          end else begin
            k <= k - 4'd1;
          end
        end
        ST_FLUSH: begin
          // release the staged action marked as final
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `HBBS_ASSERT_NOW(a_idle_hold_empty, clk, rst, state == ST_IDLE, !hold_valid, "staged in idle")
  `HBBS_ASSERT_NOW(a_up_mask_range, clk, rst, state == ST_TREE_UP, k <= 4'(REG_W-1), "bad mask")
  `HBBS_ASSERT_NEXT(a_last_drains, clk, rst, last_done, !hold_valid, "staging busy after last")

endmodule

// ===== tb/sv/bcast_sched_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcast_sched_checker
// Passive checker for the binomial broadcast schedule unit. It tracks the
// register writes, predicts each rank's action list when a query transaction
// is taken, and compares every result transaction with the oldest expected
// action.
// ---------------------------------------------------------------------------
module bcast_sched_checker
  import hbbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  item_t            item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  result_t          result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output int unsigned      pending,
  output int unsigned      fails,
  output int unsigned      n_queries,
  output int unsigned      n_actions
);

  localparam int unsigned SCHED_CAP = 24;

  // shadow copies of the registers, raw as written
  logic [REG_W-1:0] comm_reg;
  logic [REG_W-1:0] grp_reg;

  result_t action_q[$];  // expected actions, oldest first
  result_t plan_q[$];    // actions of the query being planned

  // zero counts as one, anything past the rank limit saturates
  function automatic int unsigned fit_reg(logic [REG_W-1:0] v);
    int unsigned f;
    f = 32'(v);
    if (f == 0) begin
      f = 1;
    end else if (f > MAX_RANKS) begin
      f = MAX_RANKS;
    end
    return f;
  endfunction

  function automatic void add_action(logic op_v, int unsigned who, logic [1:0] ph);
    result_t a;
    if (plan_q.size() < SCHED_CAP) begin
      a.op      = op_v;
      a.peer    = who[RANK_W-1:0];
      a.phase   = ph;
      a.is_last = 1'b0;
      plan_q.push_back(a);
    end
  endfunction

  // one binomial level: receive from parent, then children highest bit first
  function automatic void walk_tree(int unsigned idx, int unsigned lsize,
                                    int unsigned scale, int unsigned offset,
                                    int unsigned limit, logic [1:0] ph);
    int unsigned m;
    bit          found;
    m     = 1;
    found = 1'b0;
    while (m < lsize && !found) begin
      if ((idx & m) != 0) begin
        add_action(OP_RECV, offset + (idx - m) * scale, ph);
        found = 1'b1;
      end else begin
        m = m << 1;
      end
    end
    m = m >> 1;
    while (m > 0) begin
      if (idx < lsize && offset + (idx + m) * scale < limit)
        add_action(OP_SEND, offset + (idx + m) * scale, ph);
      m = m >> 1;
    end
  endfunction

  function automatic void plan_schedule(item_t it);
    int unsigned n_ranks, g, r, node, n_nodes, local_idx, first, local_size;
    result_t     tail;
    n_ranks    = fit_reg(comm_reg);
    g          = fit_reg(grp_reg);
    r          = 32'(it.rank);
    node       = r / g;
    n_nodes    = (n_ranks - 1) / g + 1;
    local_idx  = r % g;
    first      = node * g;
    // the trailing group may be short
    local_size = (first == (n_ranks / g) * g) ? n_ranks - first : g;
    plan_q.delete();
    if (it.root != '0) begin
      if (it.rank == it.root) begin
        add_action(OP_SEND, 0, PH_ROOT);
      end else if (it.rank == '0) begin
        add_action(OP_RECV, 32'(it.root), PH_ROOT);
      end
    end
    if (local_idx == 0) walk_tree(node, n_nodes, g, 0, n_ranks, PH_INTER);
    walk_tree(local_idx, local_size, 1, first, n_ranks, PH_INTRA);
    if (plan_q.size() > 0) begin
      tail = plan_q.pop_back();
      tail.is_last = 1'b1;
      plan_q.push_back(tail);
    end
    foreach (plan_q[i]) action_q.push_back(plan_q[i]);
  endfunction

  function automatic void check_action(result_t got);
    result_t want;
    if (action_q.size() == 0) begin
      $error("unexpected result: op %0d peer %0d phase %0d is_last %0d",
             got.op, got.peer, got.phase, got.is_last);
      fails++;
    end else begin
      want = action_q.pop_front();
      n_actions++;
      if (got.op !== want.op) begin
        $error("op: expected %0d, got %0d", want.op, got.op);
        fails++;
      end
      if (got.peer !== want.peer) begin
        $error("peer: expected %0d, got %0d", want.peer, got.peer);
        fails++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        fails++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
        fails++;
      end
    end
  endfunction

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      comm_reg = REG_W'(1);
      grp_reg  = REG_W'(1);
      action_q.delete();
    end else begin
      if (result_valid && result_ready) check_action(result);
      if (item_valid && item_ready) begin
        plan_schedule(item);
        n_queries++;
      end
      if (cfg_we) begin
        if (cfg_index == REG_COMM_SIZE) begin
          comm_reg = cfg_data;
        end else begin
          grp_reg = cfg_data;
        end
      end
    end
    pending = action_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the binomial broadcast schedule unit. A directed
// pass covers register extremes, short last groups, out-of-range ranks and
// roots; then random rank queries run under a dozen register settings, most
// with random idle bursts on both channels. Checking lives in bcast_sched_checker.
// ---------------------------------------------------------------------------
module tb;
  import hbbs_pkg::*;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  item_t            item;
  logic             result_valid;
  logic             result_ready;
  result_t          result;
  logic             cfg_we;
  logic             cfg_index;
  logic [REG_W-1:0] cfg_data;

  int unsigned pending, fails, n_queries, n_actions;
  int unsigned n_settings;
  bit          idle_on;

  hierarchical_binomial_bcast_schedule_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bcast_sched_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .fails        (fails),
    .n_queries    (n_queries),
    .n_actions    (n_actions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // result side: random back-pressure bursts while idling is enabled
  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      result_ready = 1'b1;
      @(negedge clk);
    end
  end

  // one query transaction; valid stays up across back-to-back queries
  task automatic send_req(input int unsigned rk, input int unsigned rt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item_valid = 1'b1;
    item.rank  = rk[RANK_W-1:0];
    item.root  = rt[RANK_W-1:0];
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all expected actions, then let a silent query finish
  task automatic settle();
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_cfg(input int unsigned comm, input int unsigned grp);
    cfg_we    = 1'b1;
    cfg_index = REG_COMM_SIZE;
    cfg_data  = REG_W'(comm);
    @(negedge clk);
    cfg_index = REG_GROUP_SIZE;
    cfg_data  = REG_W'(grp);
    @(negedge clk);
    cfg_we    = 1'b0;
    n_settings++;
  endtask

  initial begin
    int unsigned c, gs;
    int unsigned eff, rk, rt;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_COMM_SIZE;
    cfg_data   = '0;
    idle_on    = 1'b1;
    n_settings = 1;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset registers: one rank, only the root forward can appear
    send_req(0, 0);
    send_req(0, 1023);
    send_req(1023, 1023);
    settle();

    // short last group, ranks past the end
    write_cfg(10, 4);
    send_req(0, 0);
    send_req(3, 0);
    send_req(4, 0);
    send_req(8, 0);
    send_req(9, 0);
    send_req(0, 7);
    send_req(7, 7);
    send_req(5, 2);
    send_req(15, 0);
    send_req(1023, 0);
    settle();

    // zero registers read as one
    write_cfg(0, 0);
    send_req(0, 0);
    send_req(0, 3);
    send_req(3, 3);
    settle();

    // oversize registers saturate: one group of all ranks
    write_cfg(2047, 2047);
    send_req(0, 0);
    send_req(1023, 0);
    send_req(512, 1);
    send_req(1, 1);
    send_req(0, 512);
    settle();

    // singleton groups: inter-group tree only
    write_cfg(1024, 1);
    send_req(0, 0);
    send_req(1023, 0);
    send_req(341, 700);
    settle();

    // random queries under a series of settings
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin c = 1024; gs = 32; end
        1: begin c = 1000; gs = 1; end
        2: begin c = 2047; gs = 0; end
        3: begin c = 7; gs = 1024; end
        default: begin
          case ($urandom_range(0, 3))
            0:       c = $urandom_range(2, 40);
            1, 2:    c = $urandom_range(41, 1024);
            default: c = $urandom_range(0, 2047);
          endcase
          case ($urandom_range(0, 4))
            0:       gs = $urandom_range(1, 4);
            1, 2:    gs = $urandom_range(5, 64);
            3:       gs = $urandom_range(65, 1024);
            default: gs = $urandom_range(0, 2047);
          endcase
        end
      endcase
      idle_on = (p < 10) && (p != 4);
      write_cfg(c, gs);
      eff = (c == 0) ? 1 : ((c > MAX_RANKS) ? MAX_RANKS : c);
      for (int k = 0; k < 40; k++) begin
        rk = ($urandom_range(0, 9) < 8) ? $urandom_range(0, eff - 1) : $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
          0, 1, 2: rt = 0;
          8, 9:    rt = $urandom_range(0, 1023);
          default: rt = $urandom_range(0, eff - 1);
        endcase
        if ($urandom_range(0, 7) == 0) rk = rt;
        send_req(rk, rt);
      end
      settle();
    end

    $display("tb: %0d rank queries over %0d register settings, %0d schedule actions matched",
             n_queries, n_settings, n_actions);
    if (fails == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
